### design/rbox_pkg.sv
package rbox_pkg;

	localparam int NUM_REGS = 6;

	localparam int REG_BOX_LOW_X  = 0;
	localparam int REG_BOX_LOW_Y  = 1;
	localparam int REG_BOX_LOW_Z  = 2;
	localparam int REG_BOX_HIGH_X = 3;
	localparam int REG_BOX_HIGH_Y = 4;
	localparam int REG_BOX_HIGH_Z = 5;

	typedef struct packed {
		logic neg;
		logic dzero;
		logic npos;
		logic nneg;
	} slab_flag_t;

endpackage

### design/rbox_req_if.sv
interface rbox_req_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] start_x;
	logic signed [COORD_WIDTH-1:0] start_y;
	logic signed [COORD_WIDTH-1:0] start_z;
	logic signed [COORD_WIDTH-1:0] dir_x;
	logic signed [COORD_WIDTH-1:0] dir_y;
	logic signed [COORD_WIDTH-1:0] dir_z;

	modport source (output valid, start_x, start_y, start_z, dir_x, dir_y, dir_z, input ready);
	modport sink (input valid, start_x, start_y, start_z, dir_x, dir_y, dir_z, output ready);
endinterface

### design/rbox_rsp_if.sv
interface rbox_rsp_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] hit_x;
	logic signed [COORD_WIDTH-1:0] hit_y;
	logic signed [COORD_WIDTH-1:0] hit_z;
	logic                          hit_valid;

	modport source (output valid, hit_x, hit_y, hit_z, hit_valid, input ready);
	modport sink (input valid, hit_x, hit_y, hit_z, hit_valid, output ready);
endinterface

### design/rbox_div.sv
module rbox_div
	import rbox_pkg::*;
#(
	parameter int NW = 49,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          adv,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  slab_flag_t    flg_in,
	output logic [NW-1:0] quo,
	output slab_flag_t    flg_out
);

	// one quotient bit per stage, restoring
	logic [DW-1:0] rem_q [NW-1];
	logic [DW-1:0] den_q [NW-1];
	logic [NW-1:0] aq_q  [NW];
	slab_flag_t    flg_q [NW];

	logic [DW-1:0] rem_w [NW];
	logic [DW-1:0] den_w [NW];
	logic [NW-1:0] aq_w  [NW];
	slab_flag_t    flg_w [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0] sh_c;
		logic [DW:0] df_c;
		logic        ge_c;

		if (k == 0) begin : g_first
			assign rem_w[k] = '0;
			assign den_w[k] = den;
			assign aq_w[k]  = num;
			assign flg_w[k] = flg_in;
		end else begin : g_next
			assign rem_w[k] = rem_q[k-1];
			assign den_w[k] = den_q[k-1];
			assign aq_w[k]  = aq_q[k-1];
			assign flg_w[k] = flg_q[k-1];
		end

		assign sh_c = {rem_w[k], aq_w[k][NW-1]};
		assign ge_c = sh_c >= {1'b0, den_w[k]};
		assign df_c = sh_c - {1'b0, den_w[k]};

		always_ff @(posedge clk) begin
			if (adv) begin
				aq_q[k]  <= {aq_w[k][NW-2:0], ge_c};
				flg_q[k] <= flg_w[k];
			end
		end

		if (k < NW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_q[k] <= ge_c ? df_c[DW-1:0] : sh_c[DW-1:0];
					den_q[k] <= den_w[k];
				end
			end
		end
	end

	assign quo     = aq_q[NW-1];
	assign flg_out = flg_q[NW-1];

endmodule

### design/ray_box_slab_intersection.sv
// Throughput: one request per cycle, stalled while the output buffer is full;
// six dividers retire one quotient bit per stage.
// A two-entry output buffer keeps the pipeline moving while one result waits.
// Reset (arst_n low, asynchronous) empties the pipeline and the output buffer and
// sets the box to the unit cube.
module ray_box_slab_intersection
	import rbox_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16,
	localparam int PDW = (COORD_WIDTH > 32) ? 64 : 32,
	localparam int AS  = (PDW > 32) ? 3 : 2,
	localparam int AW  = AS + 3
) (
	input  logic           clk,
	input  logic           arst_n,
	rbox_req_if.sink       req,
	rbox_rsp_if.source     rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [AW-1:0]  paddr,
	input  logic [PDW-1:0] pwdata,
	output logic [PDW-1:0] prdata,
	output logic           pready
);

	localparam int W  = COORD_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int NW = W + F + 1;

	localparam logic signed [W-1:0] CMAX  = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] CMIN  = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] T_ONE = {{(W-1){1'b0}}, 1'b1} << F;
	localparam logic [NW-1:0] QMAX = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [NW-1:0] QNEG = {{(NW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic signed [W-1:0] x;
		logic signed [W-1:0] y;
		logic signed [W-1:0] z;
		logic                v;
	} rsp_t;

	// configuration
	logic signed [W-1:0] box_q [NUM_REGS];
	logic [2:0]          cidx;
	logic                cwr;

	assign cidx   = paddr[AW-1:AS];
	assign cwr    = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				box_q[i] <= (i < REG_BOX_HIGH_X) ? '0 : T_ONE;
			end
		end else if (cwr && (int'(cidx) < NUM_REGS)) begin
			box_q[cidx] <= pwdata[W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (int'(cidx) < NUM_REGS) begin
			prdata = PDW'($unsigned(box_q[cidx]));
		end
	end

	// flow control
	logic [1:0] cnt_q;
	logic       adv;

	assign adv       = cnt_q != 2'd2;
	assign req.ready = adv;

	// stage 1: register inputs, numerators
	logic                v_s1;
	logic [6*W-1:0]      sd_s1;
	logic signed [W:0]   num_s1 [6];
	logic signed [W-1:0] st_c [3];
	logic signed [W-1:0] dr_c [3];

	assign st_c[0] = req.start_x;
	assign st_c[1] = req.start_y;
	assign st_c[2] = req.start_z;
	assign dr_c[0] = req.dir_x;
	assign dr_c[1] = req.dir_y;
	assign dr_c[2] = req.dir_z;

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s1 <= {dr_c[2], dr_c[1], dr_c[0], st_c[2], st_c[1], st_c[0]};
			for (int a = 0; a < 3; a++) begin
				num_s1[a]   <= {box_q[a][W-1], box_q[a]} - {st_c[a][W-1], st_c[a]};
				num_s1[a+3] <= {box_q[a+3][W-1], box_q[a+3]} - {st_c[a][W-1], st_c[a]};
			end
		end
	end

	// stage 2: magnitudes and signs
	logic             v_s2;
	logic [6*W-1:0]   sd_s2;
	logic [W:0]       nmag_s2 [6];
	logic [W-1:0]     dmag_s2 [6];
	slab_flag_t       flg_s2  [6];

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s2 <= sd_s1;
			for (int j = 0; j < 6; j++) begin
				logic signed [W-1:0] dd;
				dd = (j < 3) ? sd_s1[(j+3)*W +: W] : sd_s1[j*W +: W];
				nmag_s2[j]      <= num_s1[j][W] ? -num_s1[j] : num_s1[j];
				dmag_s2[j]      <= dd[W-1] ? (~dd + 1'b1) : dd;
				flg_s2[j].neg   <= num_s1[j][W] ^ dd[W-1];
				flg_s2[j].dzero <= dd == '0;
				flg_s2[j].npos  <= !num_s1[j][W] && (num_s1[j] != '0);
				flg_s2[j].nneg  <= num_s1[j][W];
			end
		end
	end

	// divider stages
	logic [NW-1:0] quo_w [6];
	slab_flag_t    flg_w [6];

	for (genvar j = 0; j < 6; j++) begin : g_div
		rbox_div #(
			.NW(NW),
			.DW(W)
		) u_div (
			.clk    (clk),
			.adv    (adv),
			.num    ({nmag_s2[j], {F{1'b0}}}),
			.den    (dmag_s2[j]),
			.flg_in (flg_s2[j]),
			.quo    (quo_w[j]),
			.flg_out(flg_w[j])
		);
	end

	logic           vd_q [NW];
	logic [6*W-1:0] sd_q [NW];

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_q[0] <= sd_s2;
			for (int k = 1; k < NW; k++) begin
				sd_q[k] <= sd_q[k-1];
			end
		end
	end

	// stage 3: signed, saturated slab parameters
	logic                v_s3;
	logic [6*W-1:0]      sd_s3;
	logic signed [W-1:0] t_s3 [6];
	logic signed [W-1:0] t_c  [6];

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			if (flg_w[j].dzero) begin
				if (flg_w[j].npos) begin
					t_c[j] = CMAX;
				end else if (flg_w[j].nneg) begin
					t_c[j] = CMIN;
				end else begin
					t_c[j] = (j < 3) ? CMIN : CMAX;
				end
			end else if (!flg_w[j].neg) begin
				t_c[j] = (quo_w[j] > QMAX) ? CMAX : quo_w[j][W-1:0];
			end else begin
				t_c[j] = (quo_w[j] > QNEG) ? CMIN : -quo_w[j][W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s3 <= sd_q[NW-1];
			t_s3  <= t_c;
		end
	end

	// stage 4: per-axis near and far
	logic                v_s4;
	logic [6*W-1:0]      sd_s4;
	logic signed [W-1:0] lo_s4 [3];
	logic signed [W-1:0] hi_s4 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s4 <= sd_s3;
			for (int a = 0; a < 3; a++) begin
				lo_s4[a] <= (t_s3[a] < t_s3[a+3]) ? t_s3[a] : t_s3[a+3];
				hi_s4[a] <= (t_s3[a] < t_s3[a+3]) ? t_s3[a+3] : t_s3[a];
			end
		end
	end

	// stage 5: largest near, smallest far
	logic                v_s5;
	logic [6*W-1:0]      sd_s5;
	logic signed [W-1:0] tn_s5;
	logic signed [W-1:0] tf_s5;
	logic signed [W-1:0] tn01_c;
	logic signed [W-1:0] tf01_c;

	assign tn01_c = (lo_s4[1] > lo_s4[0]) ? lo_s4[1] : lo_s4[0];
	assign tf01_c = (hi_s4[1] < hi_s4[0]) ? hi_s4[1] : hi_s4[0];

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s5 <= sd_s4;
			tn_s5 <= (lo_s4[2] > tn01_c) ? lo_s4[2] : tn01_c;
			tf_s5 <= (hi_s4[2] < tf01_c) ? hi_s4[2] : tf01_c;
		end
	end

	// stage 6: chosen parameter
	logic                v_s6;
	logic [6*W-1:0]      sd_s6;
	logic signed [W-1:0] tt_s6;
	logic signed [W-1:0] tt_c;

	assign tt_c = (tn_s5 < 0 || tn_s5 > T_ONE) ? tf_s5 : tn_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s6 <= sd_s5;
			tt_s6 <= tt_c;
		end
	end

	// stage 7: products
	logic                  v_s7;
	logic [3*W-1:0]        st_s7;
	logic signed [2*W-1:0] prod_s7 [3];
	logic                  hv_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s7 <= sd_s6[3*W-1:0];
			hv_s7 <= (tt_s6 >= 0) && (tt_s6 <= T_ONE);
			for (int a = 0; a < 3; a++) begin
				logic signed [W-1:0] dd;
				dd = sd_s6[(a+3)*W +: W];
				prod_s7[a] <= dd * tt_s6;
			end
		end
	end

	// stage 8: floor shift, add, saturate
	logic                v_s8;
	rsp_t                out_s8;
	logic signed [W-1:0] hit_c [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			logic signed [2*W-1:0] sh;
			logic signed [2*W:0]   sum;
			logic signed [W-1:0]   ss;
			ss  = st_s7[a*W +: W];
			sh  = prod_s7[a] >>> F;
			sum = {{(W+1){ss[W-1]}}, ss} + {sh[2*W-1], sh};
			if (sum[2*W:W-1] == '0 || sum[2*W:W-1] == '1) begin
				hit_c[a] = sum[W-1:0];
			end else begin
				hit_c[a] = sum[2*W] ? CMIN : CMAX;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s8.x <= hit_c[0];
			out_s8.y <= hit_c[1];
			out_s8.z <= hit_c[2];
			out_s8.v <= hv_s7;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			for (int k = 0; k < NW; k++) begin
				vd_q[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s1    <= req.valid;
			v_s2    <= v_s1;
			vd_q[0] <= v_s2;
			for (int k = 1; k < NW; k++) begin
				vd_q[k] <= vd_q[k-1];
			end
			v_s3 <= vd_q[NW-1];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// output buffer
	rsp_t buf_q [2];
	logic wr_q;
	logic rd_q;
	logic push;
	logic pop;

	assign push = adv && v_s8;
	assign pop  = rsp.valid && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			wr_q  <= wr_q ^ push;
			rd_q  <= rd_q ^ pop;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= out_s8;
		end
	end

	assign rsp.valid     = cnt_q != 2'd0;
	assign rsp.hit_x     = buf_q[rd_q].x;
	assign rsp.hit_y     = buf_q[rd_q].y;
	assign rsp.hit_z     = buf_q[rd_q].z;
	assign rsp.hit_valid = buf_q[rd_q].v;

endmodule

### design/rbox_chk.sv
module rbox_chk
	import rbox_pkg::*;
#(
	parameter int W   = 32,
	parameter int PDW = 32,
	parameter int AS  = 2,
	parameter int AW  = 5
) (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input logic [W-1:0]   hit_x,
	input logic           psel,
	input logic           penable,
	input logic           pwrite,
	input logic [AW-1:0]  paddr,
	input logic [PDW-1:0] pwdata,
	input logic [PDW-1:0] prdata,
	input logic           pready
);

	a_rst_empty: assert property (@(posedge clk) !arst_n |=> !rsp_valid)
		else $error("result shown during reset");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit_x))
		else $error("stalled result dropped or changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_cfg_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && (int'(paddr[AW-1:AS]) < NUM_REGS))
		##1 (psel && !pwrite && paddr == $past(paddr))
		|-> prdata[W-1:0] == $past(pwdata[W-1:0]))
		else $error("register read does not return written value");

endmodule

bind ray_box_slab_intersection rbox_chk #(
	.W  (COORD_WIDTH),
	.PDW(PDW),
	.AS (AS),
	.AW (AW)
) u_rbox_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.hit_x    (rsp.hit_x),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata),
	.pready   (pready)
);
